/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Each check is sampled on clk and disabled while rst_n is low.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/salxd_pkg.sv */
`default_nettype none

package salxd_pkg;

    // Byte-level widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int CNT_W  = POS_W + 1;

    // Header sync byte
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h7E;

    // Extra bytes after the length-covered span (address..payload + check)
    localparam logic [BYTE_W:0] LEN_TAIL = 9'd3;

    // Per-byte result tag
    typedef enum logic [2:0] {
        EV_DISCARD  = 3'd0,
        EV_STORED   = 3'd1,
        EV_GOOD     = 3'd2,
        EV_BAD_SUM  = 3'd3,
        EV_OVERFLOW = 3'd4
    } evt_t;

endpackage

`default_nettype wire

/* rtl/sync_address_length_xor_deframer.sv */
// Frame receiver: one tag per received byte.
// A byte's tag is registered in the output register, or in the skid entry if that is held.
// Throughput: 1 byte per cycle; an output register plus one skid entry let the input keep
// flowing while a tag waits, and the input stalls only when both are full.
// Reset (rst_n low, asynchronous): hunting for sync, count/length/XOR/address copy cleared,
// configured address register = 0, no tag pending.
`default_nettype none

`include "assert_macros.svh"

module sync_address_length_xor_deframer #(
    parameter int MAX_FRAME = 32,
    parameter int AFTER_LEN = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  own_address,

    // Received byte channel
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [7:0]  rx_byte,

    // Tag channel
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [2:0]  event_res,
    output      logic [5:0]  position,
    output      logic [7:0]  data_byte
);

    localparam int CW = salxd_pkg::CNT_W;
    localparam int PW = salxd_pkg::POS_W;
    localparam int BW = salxd_pkg::BYTE_W;

    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_FRAME);
    localparam logic [CW-1:0] AFTER_CNT = CW'(AFTER_LEN);

    // Configuration register
    logic [BW-1:0] addr_cfg_reg;

    // Frame state
    logic [PW-1:0] byte_count_reg, byte_count_next;
    logic [BW-1:0] length_reg, length_next;
    logic [BW-1:0] xor_reg, xor_next;
    logic [BW-1:0] addr_copy_reg, addr_copy_next;

    // Output register and skid entry
    logic                out_valid_reg;
    salxd_pkg::evt_t     out_evt_reg;
    logic [PW-1:0]       out_pos_reg;
    logic [BW-1:0]       out_data_reg;
    logic                skid_valid_reg;
    salxd_pkg::evt_t     skid_evt_reg;
    logic [PW-1:0]       skid_pos_reg;
    logic [BW-1:0]       skid_data_reg;

    salxd_pkg::evt_t     evt_next;
    logic                in_fire;
    logic                out_free;
    logic [CW-1:0]       cnt;
    logic [BW:0]         len_end;
    logic [BW:0]         len_last;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign event_res = out_evt_reg;
    assign position  = out_pos_reg;
    assign data_byte = out_data_reg;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            addr_cfg_reg <= own_address;
        end
    end

    // Per-byte frame decode
    always_comb
    begin
        cnt             = {1'b0, byte_count_reg} + CW'(1);
        len_end         = {1'b0, length_reg} + salxd_pkg::LEN_TAIL;
        len_last        = {1'b0, length_reg} + 9'd1;
        evt_next        = salxd_pkg::EV_STORED;
        byte_count_next = cnt[PW-1:0];
        length_next     = length_reg;
        xor_next        = xor_reg;
        addr_copy_next  = addr_copy_reg;

        if (byte_count_reg <= PW'(1))
        begin
            // sync bytes
            if (rx_byte != salxd_pkg::SYNC_BYTE)
            begin
                evt_next        = salxd_pkg::EV_DISCARD;
                byte_count_next = '0;
            end
        end
        else if (byte_count_reg == PW'(2))
        begin
            // address byte seeds the checksum
            if (rx_byte != addr_cfg_reg)
            begin
                evt_next        = salxd_pkg::EV_DISCARD;
                byte_count_next = '0;
            end
            else
            begin
                addr_copy_next = rx_byte;
                xor_next       = rx_byte;
            end
        end
        else if (cnt >= MAX_CNT)
        begin
            evt_next        = salxd_pkg::EV_OVERFLOW;
            byte_count_next = '0;
        end
        else if ((cnt > AFTER_CNT) && ({2'b0, cnt} >= len_end))
        begin
            // check byte
            evt_next        = (rx_byte == xor_reg) ? salxd_pkg::EV_GOOD
                                                   : salxd_pkg::EV_BAD_SUM;
            byte_count_next = '0;
        end
        else if (byte_count_reg == PW'(3))
        begin
            xor_next = xor_reg ^ rx_byte;
        end
        else if (byte_count_reg == PW'(4))
        begin
            // length byte; short lengths check the address byte alone
            length_next = rx_byte;
            if (rx_byte < 8'd2)
            begin
                xor_next = addr_copy_reg;
            end
            else if (rx_byte >= 8'd3)
            begin
                xor_next = xor_reg ^ rx_byte;
            end
        end
        else if ({3'b0, byte_count_reg} <= len_last)
        begin
            xor_next = xor_reg ^ rx_byte;
        end
    end

    // Frame state update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            length_reg     <= '0;
            xor_reg        <= '0;
            addr_copy_reg  <= '0;
        end
        else if (in_fire)
        begin
            byte_count_reg <= byte_count_next;
            length_reg     <= length_next;
            xor_reg        <= xor_next;
            addr_copy_reg  <= addr_copy_next;
        end
    end

    // Output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (!out_stall)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_evt_reg  <= skid_evt_reg;
                out_pos_reg  <= skid_pos_reg;
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_free)
            begin
                out_evt_reg  <= evt_next;
                out_pos_reg  <= byte_count_reg;
                out_data_reg <= rx_byte;
            end
            else
            begin
                skid_evt_reg  <= evt_next;
                skid_pos_reg  <= byte_count_reg;
                skid_data_reg <= rx_byte;
            end
        end
    end

    // Checks
    `ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
                "skid entry held while output register empty")
    `ASSERT_NXT(a_end_rehunts, in_fire && (evt_next != salxd_pkg::EV_STORED),
                byte_count_reg == '0, "frame end or drop did not return to hunting")
    `ASSERT_IMP(a_end_after_len,
                out_valid_reg && ((out_evt_reg == salxd_pkg::EV_GOOD) ||
                                  (out_evt_reg == salxd_pkg::EV_BAD_SUM)),
                {1'b0, out_pos_reg} >= AFTER_CNT, "frame ended before the length byte span")
    `ASSERT_IMP(a_count_below_max, 1'b1, {1'b0, byte_count_reg} < MAX_CNT,
                "byte count reached the frame limit")

endmodule

`default_nettype wire
